FILE: rtl/core/kis_pkg.sv
// kis_pkg: types and constants shared by the key/index sorter modules.
// No dependencies.

package kis_pkg;

   localparam int KEY_W = 32;
   localparam int TAG_W = 16;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [TAG_W-1:0]        tag_type;

   // one-hot controller states
   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic insert;     // place the request beat into the sorted row
      logic shift_out;  // drop the head entry, move the row down
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last_entry; // exactly one entry left in the row
   } status_type;

endpackage

FILE: rtl/core/kis_datapath.sv
// kis_datapath: row of sorted key/tag cells with parallel insertion and
// head-first drain. Depends on kis_pkg.

module kis_datapath import kis_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  key_type    new_key,
   input  tag_type    new_tag,
   output status_type status,
   output key_type    head_key,
   output tag_type    head_tag
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   key_type          key_ff [DEPTH];
   key_type          key_in [DEPTH];
   tag_type          tag_ff [DEPTH];
   tag_type          tag_in [DEPTH];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [DEPTH-1:0] gt;
   logic             full;
   logic             do_insert;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign do_insert = cmd.insert && !full;

   // gt is monotonic over the occupied cells since the row stays sorted
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (key_ff[i] > new_key);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         key_in[i] = key_ff[i];
         tag_in[i] = tag_ff[i];
         if (cmd.shift_out) begin
            if (i < DEPTH - 1) begin
               key_in[i] = key_ff[i+1];
               tag_in[i] = tag_ff[i+1];
            end
         end else if (do_insert) begin
            if (i > 0 && gt[i-1]) begin
               key_in[i] = key_ff[i-1];
               tag_in[i] = tag_ff[i-1];
            end else if (gt[i] || count_ff == CNT_W'(i)) begin
               key_in[i] = new_key;
               tag_in[i] = new_tag;
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.shift_out) begin
         count_in = count_ff - CNT_W'(1);
      end else if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         key_ff[i] <= key_in[i];
         tag_ff[i] <= tag_in[i];
      end
   end

   assign status.last_entry = (count_ff == CNT_W'(1));
   assign head_key          = key_ff[0];
   assign head_tag          = tag_ff[0];

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_shift_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_out |-> count_ff != '0)
      else $error("drain from empty row");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.insert && !cmd.shift_out && !full |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the row");
`endif

endmodule

FILE: rtl/core/kis_control.sv
// kis_control: load/drain state machine and channel handshakes for the sorter.
// Depends on kis_pkg.

module kis_control import kis_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_final,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      req_beat;
   logic      rsp_beat;

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = (state_ff == ST_DRAIN);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid && !rsp_stall;

   assign cmd.insert    = req_beat;
   assign cmd.shift_out = rsp_beat;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_beat && req_final) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_beat && status.last_entry) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("load and drain active together");

   a_final_drains: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_final |=> rsp_valid)
      else $error("closing beat did not start drain");

   a_last_reloads: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && status.last_entry |=> !rsp_valid && !req_stall)
      else $error("drain did not end after last beat");
`endif

endmodule

FILE: rtl/core/key_index_sorter.sv
// key_index_sorter: collects a set of key/tag pairs and returns them in
// ascending signed key order. Depends on kis_pkg, kis_control, kis_datapath.
//
//   channel | dir | payload                                   | handshake
//   req     | in  | sort_key[31:0] tag_index[15:0] final_entry | req_valid/req_stall
//   rsp     | out | out_key[31:0] out_index[15:0] out_last      | rsp_valid/rsp_stall
//
// Load: one request beat per cycle; each pair is registered into its sorted place
// in the cell row (parallel compare across all DEPTH cells).
// Drain: after the final beat, one result beat per cycle from the row head while
// rsp_stall is low; req is stalled until the last result leaves.
// Pairs beyond DEPTH are dropped; a dropped final beat still closes the set.
// Reset is synchronous and empties the row; no clearing pass is needed.

module key_index_sorter import kis_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  key_type req_sort_key,
   input  tag_type req_tag_index,
   input  logic    req_final_entry,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output key_type rsp_out_key,
   output tag_type rsp_out_index,
   output logic    rsp_out_last
);

   cmd_type    cmd;
   status_type status;

   kis_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_final (req_final_entry),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kis_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .new_key  (req_sort_key),
      .new_tag  (req_tag_index),
      .status   (status),
      .head_key (rsp_out_key),
      .head_tag (rsp_out_index)
   );

   assign rsp_out_last = status.last_entry;

endmodule
